FILE: rtl/ecpr_pkg.sv
// package for the enhanced clock page replacement unit
// frame count, field widths, cell control types and the one-hot encoder
// no dependencies
`default_nettype none

package ecpr_pkg;

	localparam int FRAMES  = 64;
	localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	localparam int KIND_W   = 2;
	localparam int OWNER_W  = 16;
	localparam int PAGE_W   = 20;
	localparam int TGT_W    = 8;
	localparam int CHOSEN_W = 6;

	typedef logic [FRAMES-1:0]   vec_t;
	typedef logic [FRAME_W-1:0]  idx_t;
	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [OWNER_W-1:0]  owner_t;
	typedef logic [PAGE_W-1:0]   page_t;
	typedef logic [TGT_W-1:0]    tgt_t;
	typedef logic [CHOSEN_W-1:0] chosen_t;

	// item kinds
	localparam kind_t KIND_FAULT  = 2'd0;
	localparam kind_t KIND_REF    = 2'd1;
	localparam kind_t KIND_MODIFY = 2'd2;

	// broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic mark;
		logic mark_dirty;
		logic place;
		logic place_dirty;
		logic clr_all;
		logic clr_range;
		logic hand_adv;
	} cell_ctl_t;

	// state one cell shows to the sequencer
	typedef struct packed {
		logic occ;
		logic refd;
		logic dirty;
		logic hand;
	} cell_st_t;

	// one-hot vector to frame index
	function automatic idx_t onehot_idx(input vec_t v);
		idx_t r;
		r = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (v[i]) r = r | idx_t'(i);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ecpr_if.sv
// valid/ready channels of the enhanced clock page replacement unit
// command channel into the block and result channel out of it
// depends on ecpr_pkg
`default_nettype none

interface ecpr_cmd_if;
	logic                valid;
	logic                ready;
	ecpr_pkg::kind_t     kind;
	ecpr_pkg::owner_t    owner_id;
	ecpr_pkg::page_t     page_number;
	logic                dirty_in;
	ecpr_pkg::tgt_t      target_frame;

	modport source (output valid, kind, owner_id, page_number, dirty_in, target_frame,
		input ready);
	modport sink (input valid, kind, owner_id, page_number, dirty_in, target_frame,
		output ready);
endinterface

interface ecpr_res_if;
	logic                valid;
	logic                ready;
	ecpr_pkg::chosen_t   chosen_frame;
	logic                evicted_valid;
	ecpr_pkg::page_t     evicted_page;
	logic                evicted_dirty;

	modport source (output valid, chosen_frame, evicted_valid, evicted_page, evicted_dirty,
		input ready);
	modport sink (input valid, chosen_frame, evicted_valid, evicted_page, evicted_dirty,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/ecpr_cell.sv
// one frame cell: occupied, referenced and dirty bits plus its share of the clock hand
// when the hand moves, the hand bit is set if the neighbor below is the victim
// depends on ecpr_pkg
`default_nettype none

module ecpr_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire ecpr_pkg::cell_ctl_t ctl,
	input  wire                      first,
	input  wire                      tgt_hit,
	input  wire                      vict_hit,
	input  wire                      vict_prev,
	input  wire                      in_range,
	output ecpr_pkg::cell_st_t       st
);

	logic occ_q;
	logic refd_q;
	logic dirty_q;
	logic hand_q;

	// frame bits: marks, clock sweeps and page placement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= 1'b0;
			refd_q  <= 1'b0;
			dirty_q <= 1'b0;
			hand_q  <= first;
		end else begin
			if (ctl.mark && tgt_hit) begin
				refd_q <= 1'b1;
				if (ctl.mark_dirty) dirty_q <= 1'b1;
			end
			if (ctl.clr_all || (ctl.clr_range && in_range)) begin
				refd_q <= 1'b0;
			end
			if (ctl.place && vict_hit) begin
				occ_q   <= 1'b1;
				refd_q  <= 1'b1;
				dirty_q <= ctl.place_dirty;
			end
			// hand lands one frame past the victim
			if (ctl.hand_adv) hand_q <= vict_prev;
		end
	end

	assign st = '{occ: occ_q, refd: refd_q, dirty: dirty_q, hand: hand_q};

endmodule

`default_nettype wire

FILE: rtl/ecpr_find.sv
// rotating priority search over the frame vector
// returns the first requesting frame at or after a one-hot start, wrapping around
// depends on ecpr_pkg
`default_nettype none

module ecpr_find (
	input  wire ecpr_pkg::vec_t req,
	input  wire ecpr_pkg::vec_t start,
	output ecpr_pkg::vec_t      grant,
	output logic                found
);

	ecpr_pkg::vec_t upper;
	ecpr_pkg::vec_t upper_pick;
	ecpr_pkg::vec_t lower_pick;

	// requests at or above the start, then lowest set bit of each side
	assign upper      = req & ~(start - ecpr_pkg::vec_t'(1));
	assign upper_pick = upper & (~upper + ecpr_pkg::vec_t'(1));
	assign lower_pick = req & (~req + ecpr_pkg::vec_t'(1));

	assign grant = (|upper) ? upper_pick : lower_pick;
	assign found = |req;

endmodule

`default_nettype wire

FILE: rtl/enhanced_clock_page_replacement_unit.sv
// Top level: enhanced second-chance clock page replacement over a row of frame cells.
// Mark items (referenced / modified) are applied as they are taken; the next item is taken right after.
// A fault into a free frame runs a free search and the place step; with eviction it runs the
// free search, clean, dirty and last passes as needed, a page read and the place step, then goes idle.
// A result sits in an output register; the next item is taken while it waits.
// Reset empties every frame, clears referenced and dirty bits and puts the hand on frame 0.
`default_nettype none

module enhanced_clock_page_replacement_unit (
	input  wire           clk,
	input  wire           arst_n,
	ecpr_cmd_if.sink      cmd,
	ecpr_res_if.source    res
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_FREE   = 6'b000010,
		S_SRCH_A = 6'b000100,
		S_SRCH_B = 6'b001000,
		S_SRCH_C = 6'b010000,
		S_PLACE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   read_q;

	ecpr_pkg::vec_t     vict_q;
	ecpr_pkg::vec_t     vict_d;
	logic               evict_q;
	logic               evict_d;
	ecpr_pkg::page_t    page_q;
	logic               dirty_in_q;

	ecpr_pkg::vec_t     occ_vec;
	ecpr_pkg::vec_t     refd_vec;
	ecpr_pkg::vec_t     dirty_vec;
	ecpr_pkg::vec_t     hand_vec;
	ecpr_pkg::cell_st_t cell_st [ecpr_pkg::FRAMES];

	ecpr_pkg::vec_t     find_req;
	ecpr_pkg::vec_t     find_start;
	ecpr_pkg::vec_t     grant;
	logic               found;
	ecpr_pkg::vec_t     range_vec;

	ecpr_pkg::cell_ctl_t ctl;
	ecpr_pkg::idx_t      vict_idx;
	logic                out_free;
	logic                accept;

	ecpr_pkg::page_t     page_mem [ecpr_pkg::FRAMES];
	ecpr_pkg::page_t     rd_page_q;

	logic                res_valid_q;
	ecpr_pkg::chosen_t   chosen_q;
	logic                ev_valid_q;
	ecpr_pkg::page_t     ev_page_q;
	logic                ev_dirty_q;

	assign accept   = cmd.valid && cmd.ready;
	assign out_free = !res_valid_q || res.ready;
	assign vict_idx = ecpr_pkg::onehot_idx(vict_q);

	// row of frame cells
	for (genvar i = 0; i < ecpr_pkg::FRAMES; i++) begin : g_cell
		ecpr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.first    (i == 0),
			.tgt_hit  (cmd.target_frame == ecpr_pkg::tgt_t'(i)),
			.vict_hit (vict_q[i]),
			.vict_prev(vict_q[(i + ecpr_pkg::FRAMES - 1) % ecpr_pkg::FRAMES]),
			.in_range (range_vec[i]),
			.st       (cell_st[i])
		);
		assign occ_vec[i]   = cell_st[i].occ;
		assign refd_vec[i]  = cell_st[i].refd;
		assign dirty_vec[i] = cell_st[i].dirty;
		assign hand_vec[i]  = cell_st[i].hand;
	end

	// search request per pass: free frames, clean unreferenced, dirty unreferenced
	always_comb begin
		find_req   = ~refd_vec & ~dirty_vec;
		find_start = hand_vec;
		case (state_q)
			S_FREE: begin
				find_req   = ~occ_vec;
				find_start = ecpr_pkg::vec_t'(1);
			end
			S_SRCH_B: find_req = ~refd_vec & dirty_vec;
			default:  find_req = ~refd_vec & ~dirty_vec;
		endcase
	end

	ecpr_find u_find (
		.req  (find_req),
		.start(find_start),
		.grant(grant),
		.found(found)
	);

	// frames swept from the hand up to the victim lose their referenced bit
	always_comb begin
		if (grant >= hand_vec) begin
			range_vec = ~(hand_vec - ecpr_pkg::vec_t'(1)) & (grant - ecpr_pkg::vec_t'(1));
		end else begin
			range_vec = ~(hand_vec - ecpr_pkg::vec_t'(1)) | (grant - ecpr_pkg::vec_t'(1));
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		vict_d  = vict_q;
		evict_d = evict_q;
		ctl     = '0;
		ctl.mark_dirty  = (cmd.kind == ecpr_pkg::KIND_MODIFY) && cmd.dirty_in;
		ctl.place_dirty = dirty_in_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd.kind == ecpr_pkg::KIND_FAULT) begin
						state_d = S_FREE;
					end else if ((cmd.kind == ecpr_pkg::KIND_REF) ||
						(cmd.kind == ecpr_pkg::KIND_MODIFY)) begin
						ctl.mark = 1'b1;
					end
				end
			end
			S_FREE: begin
				vict_d = grant;
				if (found) begin
					evict_d = 1'b0;
					state_d = S_PLACE;
				end else begin
					evict_d = 1'b1;
					state_d = S_SRCH_A;
				end
			end
			S_SRCH_A: begin
				vict_d  = grant;
				state_d = found ? S_PLACE : S_SRCH_B;
			end
			S_SRCH_B: begin
				vict_d = grant;
				if (found) begin
					ctl.clr_range = 1'b1;
					state_d = S_PLACE;
				end else begin
					ctl.clr_all = 1'b1;
					state_d = S_SRCH_C;
				end
			end
			S_SRCH_C: begin
				// every frame is dirty when nothing clean turns up: the hand frame goes
				vict_d  = found ? grant : hand_vec;
				state_d = S_PLACE;
			end
			S_PLACE: begin
				if (out_free && !read_q) begin
					ctl.place    = 1'b1;
					ctl.hand_adv = evict_q;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			read_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// page read flag, set as an eviction victim is chosen; the place step waits while it is up
			read_q  <= evict_d && (state_q != S_PLACE) && (state_d == S_PLACE);
		end
	end

	always_ff @(posedge clk) begin
		vict_q  <= vict_d;
		evict_q <= evict_d;
		if (accept) begin
			page_q     <= cmd.page_number;
			dirty_in_q <= cmd.dirty_in;
		end
	end

	// page number store, registered read
	always_ff @(posedge clk) begin
		if (ctl.place) page_mem[vict_idx] <= page_q;
		if (read_q) rd_page_q <= page_mem[vict_idx];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.place) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.place) begin
			chosen_q   <= ecpr_pkg::chosen_t'(vict_idx);
			ev_valid_q <= evict_q;
			ev_page_q  <= evict_q ? rd_page_q : '0;
			ev_dirty_q <= evict_q && (|(dirty_vec & vict_q));
		end
	end

	assign cmd.ready         = (state_q == S_IDLE);
	assign res.valid         = res_valid_q;
	assign res.chosen_frame  = chosen_q;
	assign res.evicted_valid = ev_valid_q;
	assign res.evicted_page  = ev_page_q;
	assign res.evicted_dirty = ev_dirty_q;

endmodule

`default_nettype wire

FILE: rtl/ecpr_chk.sv
// port-level checks for the enhanced clock page replacement unit
// bound to the top level; sees only its channel ports
// depends on ecpr_pkg and the top level
`default_nettype none

module ecpr_chk (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    cmd_valid,
	input wire                    cmd_ready,
	input wire ecpr_pkg::kind_t   cmd_kind,
	input wire                    res_valid,
	input wire                    res_ready,
	input wire ecpr_pkg::chosen_t res_chosen_frame,
	input wire                    res_evicted_valid,
	input wire ecpr_pkg::page_t   res_evicted_page,
	input wire                    res_evicted_dirty
);

	// a stalled result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_chosen_frame) &&
			$stable(res_evicted_page) && $stable(res_evicted_dirty))
		else $error("result changed while stalled");

	// a free-frame fault reports nothing evicted
	a_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_evicted_valid |-> res_evicted_page == '0 && !res_evicted_dirty)
		else $error("eviction fields set without an eviction");

	// mark items never produce a result
	a_mark_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_kind != ecpr_pkg::KIND_FAULT && !res_valid
			|=> !res_valid)
		else $error("result after a mark item");

	// the block is not ready in the cycle after it takes a fault
	a_fault_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_kind == ecpr_pkg::KIND_FAULT |=> !cmd_ready)
		else $error("item taken right after a fault");

endmodule

bind enhanced_clock_page_replacement_unit ecpr_chk u_ecpr_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.cmd_kind         (cmd.kind),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_chosen_frame (res.chosen_frame),
	.res_evicted_valid(res.evicted_valid),
	.res_evicted_page (res.evicted_page),
	.res_evicted_dirty(res.evicted_dirty)
);

`default_nettype wire

FILE: bench/replacement_checker.sv
`timescale 1ns / 100ps
// checker for the enhanced clock page replacement unit: keeps its own frame table and
// clock hand, predicts each fault result and compares it with what the block hands out
// depends on ecpr_pkg and the channel interfaces in ecpr_if

module replacement_checker
	import ecpr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ecpr_cmd_if  cmd,
	ecpr_res_if  res,
	output int   mismatches,
	output int   outstanding
);

	typedef struct {
		logic   occupied;
		owner_t owner;
		page_t  page;
		logic   referenced;
		logic   dirty;
	} frame_t;

	typedef struct packed {
		chosen_t frame;
		logic    evicted;
		page_t   page;
		logic    dirty;
	} placement_t;

	frame_t     frames [FRAMES];
	idx_t       hand;
	placement_t pending_placements [$];

	function automatic idx_t frame_after(input idx_t f);
		return (f == idx_t'(FRAMES - 1)) ? '0 : f + 1'b1;
	endfunction

	// clean and unreferenced first, then dirty and unreferenced while
	// stripping referenced bits, around again until something qualifies
	function automatic idx_t sweep_for_victim();
		int victim;
		victim = -1;
		while (victim < 0) begin
			for (int i = 0; i < FRAMES && victim < 0; i++) begin
				if (!frames[hand].referenced && !frames[hand].dirty) victim = int'(hand);
				else hand = frame_after(hand);
			end
			for (int i = 0; i < FRAMES && victim < 0; i++) begin
				if (!frames[hand].referenced && frames[hand].dirty) begin
					victim = int'(hand);
				end else begin
					frames[hand].referenced = 1'b0;
					hand = frame_after(hand);
				end
			end
		end
		return idx_t'(victim);
	endfunction

	// lowest free frame if any, otherwise evict; the hand only moves on eviction
	function automatic placement_t place_faulting_page(input owner_t owner, input page_t page,
		input logic dirty);
		placement_t p;
		int         slot;
		idx_t       f;
		slot = -1;
		for (int i = 0; i < FRAMES && slot < 0; i++) begin
			if (!frames[i].occupied) slot = i;
		end
		if (slot >= 0) begin
			f = idx_t'(slot);
			p = '{frame: chosen_t'(f), evicted: 1'b0, page: '0, dirty: 1'b0};
		end else begin
			f = sweep_for_victim();
			p = '{frame: chosen_t'(f), evicted: 1'b1, page: frames[f].page,
				dirty: frames[f].dirty};
			hand = frame_after(f);
		end
		frames[f] = '{occupied: 1'b1, owner: owner, page: page, referenced: 1'b1, dirty: dirty};
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		placement_t want;
		placement_t got;
		if (!arst_n) begin
			foreach (frames[i]) begin
				frames[i] = '{occupied: 1'b0, owner: '0, page: '0, referenced: 1'b0,
					dirty: 1'b0};
			end
			hand = '0;
			pending_placements.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// results first: a result never belongs to a command taken at the same edge
			if (res.valid && res.ready) begin
				got = '{frame: res.chosen_frame, evicted: res.evicted_valid,
					page: res.evicted_page, dirty: res.evicted_dirty};
				if (pending_placements.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected fault result frame %0d evicted %b page %h dirty %b",
							$time, got.frame, got.evicted, got.page, got.dirty);
				end else begin
					want = pending_placements.pop_front();
					if (got.frame !== want.frame || got.evicted !== want.evicted ||
						got.page !== want.page || got.dirty !== want.dirty) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: fault result mismatch: expected frame %0d evicted %b",
								" page %h dirty %b, got frame %0d evicted %b page %h dirty %b"},
								$time, want.frame, want.evicted, want.page, want.dirty,
								got.frame, got.evicted, got.page, got.dirty);
					end
				end
			end

			// update the frame table for the accepted item
			if (cmd.valid && cmd.ready) begin
				case (cmd.kind)
					KIND_FAULT: begin
						pending_placements.push_back(place_faulting_page(cmd.owner_id,
							cmd.page_number, cmd.dirty_in));
					end
					KIND_REF, KIND_MODIFY: begin
						// out-of-range targets are dropped; empty frames get marked anyway
						if (int'(cmd.target_frame) < FRAMES) begin
							frames[cmd.target_frame].referenced = 1'b1;
							if (cmd.kind == KIND_MODIFY && cmd.dirty_in)
								frames[cmd.target_frame].dirty = 1'b1;
						end
					end
					default: ;
				endcase
			end
			outstanding <= pending_placements.size();
		end
	end

endmodule

FILE: bench/tb_enhanced_clock_page_replacement_unit.sv
`timescale 1ns / 100ps
// testbench top for the enhanced clock page replacement unit: drives page faults and
// mark items, paces the result channel and gives the verdict
// depends on ecpr_pkg, ecpr_if, the block and replacement_checker

module tb_enhanced_clock_page_replacement_unit;
	import ecpr_pkg::*;

	localparam kind_t KIND_UNUSED  = 2'd3;
	localparam int    ITEM_TARGET  = 1750;
	localparam int    HOLD_OFF     = 300;
	localparam int    STALL_LIMIT  = 4000;
	localparam int    DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   sender_idle_pct = 36;
	int   receiver_idle_pct = 48;
	int   hold_requests = 0;
	int   hold_served = 0;
	int   hold_left = 0;
	int   quiet_cycles = 0;
	int   mismatches;
	int   outstanding;

	ecpr_cmd_if cmd_ch ();
	ecpr_res_if res_ch ();

	enhanced_clock_page_replacement_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	replacement_checker placement_check (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: long hold-off on request, otherwise random back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_requests != hold_served) begin
			res_ch.ready <= 1'b0;
			hold_served <= hold_requests;
			hold_left <= HOLD_OFF;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	task automatic send_item(input kind_t kind, input owner_t owner, input page_t page,
		input logic dirty, input tgt_t target);
		while ($urandom_range(99) < sender_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.kind         <= kind;
		cmd_ch.owner_id     <= owner;
		cmd_ch.page_number  <= page;
		cmd_ch.dirty_in     <= dirty;
		cmd_ch.target_frame <= target;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	// one random item; marks mostly hit real frames, a tenth take a target from the full 8-bit range
	task automatic send_random_item(input int fault_pct);
		int    roll;
		kind_t kind;
		tgt_t  target;
		roll = $urandom_range(99);
		if ($urandom_range(9) == 0) target = tgt_t'($urandom_range(255));
		else target = tgt_t'($urandom_range(FRAMES - 1));
		if (roll < fault_pct) kind = KIND_FAULT;
		else if (roll < 97) kind = ($urandom_range(1) != 0) ? KIND_MODIFY : KIND_REF;
		else kind = KIND_UNUSED;
		send_item(kind, owner_t'($urandom), page_t'($urandom), $urandom_range(1) != 0, target);
	endtask

	initial begin
		int  counted;
		int  fault_pct;
		bit  pressure_done;
		counted = 0;
		fault_pct = 30;
		pressure_done = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.kind = '0;
		cmd_ch.owner_id = '0;
		cmd_ch.page_number = '0;
		cmd_ch.dirty_in = 1'b0;
		cmd_ch.target_frame = '0;
		res_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, free-frame faults, marks on empty and out-of-range frames, an unused kind
		send_item(KIND_FAULT, 16'h0000, 20'h00000, 1'b0, 8'd0);
		send_item(KIND_FAULT, 16'hFFFF, 20'hFFFFF, 1'b1, 8'd255);
		send_item(KIND_REF, 16'hFFFF, 20'hFFFFF, 1'b1, 8'd0);
		send_item(KIND_REF, 16'h0000, 20'h00000, 1'b0, 8'd63);
		send_item(KIND_MODIFY, 16'h0000, 20'h00000, 1'b1, 8'd63);
		send_item(KIND_MODIFY, 16'h0000, 20'h00000, 1'b0, 8'd1);
		send_item(KIND_MODIFY, 16'h0000, 20'h00000, 1'b1, 8'd62);
		send_item(KIND_REF, 16'h1234, 20'h12345, 1'b1, 8'd64);
		send_item(KIND_MODIFY, 16'h1234, 20'h12345, 1'b1, 8'd255);
		send_item(KIND_MODIFY, 16'h1234, 20'h12345, 1'b0, 8'd128);
		send_item(KIND_UNUSED, 16'hFFFF, 20'hFFFFF, 1'b1, 8'd5);
		send_item(KIND_FAULT, 16'h5A5A, 20'hA5A5A, 1'b1, 8'd0);
		send_item(KIND_FAULT, 16'hA5A5, 20'h5A5A5, 1'b0, 8'd0);
		send_item(KIND_REF, 16'h0000, 20'h00000, 1'b0, 8'd2);

		// random part: fault-heavy, mark-heavy and balanced stretches picked at random
		while (counted < ITEM_TARGET) begin
			if (counted < ITEM_TARGET / 3) begin
				sender_idle_pct <= 36;
				receiver_idle_pct <= 48;
			end else if (counted < 2 * ITEM_TARGET / 3) begin
				sender_idle_pct <= 48;
				receiver_idle_pct <= 36;
			end else begin
				sender_idle_pct <= 0;
				receiver_idle_pct <= 0;
				// fill the block while results are held back
				if (!pressure_done) begin
					pressure_done = 1'b1;
					hold_requests <= hold_requests + 1;
					repeat (24) begin
						send_item(KIND_FAULT, owner_t'($urandom), page_t'($urandom),
							$urandom_range(1) != 0, tgt_t'($urandom_range(255)));
						counted++;
					end
				end
			end
			if (counted % 40 == 0) begin
				case ($urandom_range(2))
					0: fault_pct = 30;
					1: fault_pct = 70;
					default: fault_pct = 10;
				endcase
			end
			send_random_item(fault_pct);
			counted++;
		end

		// drain and decide
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ecpr_pkg.sv
rtl/ecpr_if.sv
rtl/ecpr_cell.sv
rtl/ecpr_find.sv
rtl/enhanced_clock_page_replacement_unit.sv
rtl/ecpr_chk.sv
bench/replacement_checker.sv
bench/tb_enhanced_clock_page_replacement_unit.sv
